### rtl/core/sva_pkg.sv
// Package for the signed vector angle pipeline: widths, angle constants,
// CORDIC arctangent table and the flag bundle carried beside the data.
// No dependencies.
package sva_pkg;

	localparam int ANGLE_W = 9;
	localparam int ACUTE_W = 7;
	localparam int ZW = 33;
	localparam int ZQ_W = 31;
	localparam int PROD_DEG_W = 40;
	localparam int MAG_LIMIT_BIT = 61;
	localparam int NORM_SHW = 2;
	localparam int MAX_ITER = 32;

	localparam logic [ZQ_W-1:0] TURN_QUARTER = 31'h4000_0000;
	localparam logic [8:0] DEG_PER_TURN = 9'd360;
	localparam logic signed [ANGLE_W-1:0] DEG_RIGHT = 9'sd90;
	localparam logic signed [ANGLE_W-1:0] DEG_STRAIGHT = 9'sd180;
	localparam logic signed [ANGLE_W-1:0] DEG_ZERO = 9'sd0;

	// atan(2^-i), 2^32 units per turn
	localparam logic [31:0] ATAN_UNITS [MAX_ITER] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	typedef struct packed {
		logic zero_vec;
		logic crs_zero;
		logic dot_zero;
		logic dot_neg;
		logic crs_neg;
	} flags_t;

endpackage

### rtl/core/signed_vector_angle_degrees.sv
// Signed angle from vector A to vector B in whole degrees.
// Products, sums, normalize, unrolled CORDIC (one iteration per stage), scale, output.
// Depends on sva_pkg.
//
//  channel | signals                                        | dir
//  in      | in_valid, in_ready, first_x/y, second_x/y      | sink
//  out     | out_valid, out_ready, angle_deg                | source
//
// CORDIC_ITERATIONS is capped at 32; one transaction per cycle while the output is not stalled.
// The pipeline length is set by the CORDIC stages, one shift-add iteration each.
// All stages advance together; a stalled output holds the whole pipeline.
// Reset clears the stage valid bits only.
module signed_vector_angle_degrees #(
	parameter int COMPONENT_WIDTH = 16,
	parameter int CORDIC_ITERATIONS = 20
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [COMPONENT_WIDTH-1:0] first_x,
	input  logic signed [COMPONENT_WIDTH-1:0] first_y,
	input  logic signed [COMPONENT_WIDTH-1:0] second_x,
	input  logic signed [COMPONENT_WIDTH-1:0] second_y,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [sva_pkg::ANGLE_W-1:0] angle_deg
);
	import sva_pkg::*;

	localparam int N = (CORDIC_ITERATIONS > MAX_ITER) ? MAX_ITER : CORDIC_ITERATIONS;
	localparam int PW = 2 * COMPONENT_WIDTH;
	localparam int SW = PW + 1;
	localparam int MW = PW;
	localparam int NW = (MW > MAG_LIMIT_BIT) ? MAG_LIMIT_BIT : MW;
	localparam int XW = NW + 3;
	localparam int DEPTH = N + 5;

	logic [DEPTH-1:0] vld_s;
	logic adv;

	assign adv = !vld_s[DEPTH-1] || out_ready;
	assign in_ready = adv;
	assign out_valid = vld_s[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[DEPTH-2:0], in_valid};
		end
	end

	// stage 1: products
	logic signed [PW-1:0] p_axbx_s1, p_ayby_s1, p_axby_s1, p_aybx_s1;
	logic zero_vec_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			p_axbx_s1 <= PW'(first_x) * PW'(second_x);
			p_ayby_s1 <= PW'(first_y) * PW'(second_y);
			p_axby_s1 <= PW'(first_x) * PW'(second_y);
			p_aybx_s1 <= PW'(first_y) * PW'(second_x);
			zero_vec_s1 <= (first_x == '0 && first_y == '0) ||
				(second_x == '0 && second_y == '0);
		end
	end

	// stage 2: dot and cross
	logic signed [SW-1:0] dot_s2, crs_s2;
	logic zero_vec_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			dot_s2 <= SW'(p_axbx_s1) + SW'(p_ayby_s1);
			crs_s2 <= SW'(p_axby_s1) - SW'(p_aybx_s1);
			zero_vec_s2 <= zero_vec_s1;
		end
	end

	// stage 3: magnitudes, normalize into CORDIC range
	logic [SW-1:0] dot_abs, crs_abs;
	logic [MW-1:0] dot_mag, crs_mag, mag_or;
	logic [NORM_SHW-1:0] nshift;
	logic [MW-1:0] dot_shr, crs_shr;
	flags_t fl_in;

	always_comb begin
		dot_abs = dot_s2[SW-1] ? SW'(-dot_s2) : SW'(dot_s2);
		crs_abs = crs_s2[SW-1] ? SW'(-crs_s2) : SW'(crs_s2);
		dot_mag = dot_abs[MW-1:0];
		crs_mag = crs_abs[MW-1:0];
		mag_or = dot_mag | crs_mag;
		nshift = '0;
		for (int k = MAG_LIMIT_BIT; k < MW; k++) begin
			if (mag_or[k]) nshift = NORM_SHW'(k - MAG_LIMIT_BIT + 1);
		end
		dot_shr = dot_mag >> nshift;
		crs_shr = crs_mag >> nshift;
		fl_in.zero_vec = zero_vec_s2;
		fl_in.crs_zero = (crs_mag == '0);
		fl_in.dot_zero = (dot_mag == '0);
		fl_in.dot_neg = dot_s2[SW-1];
		fl_in.crs_neg = crs_s2[SW-1];
	end

	logic signed [XW-1:0] cx_s [N+1];
	logic signed [XW-1:0] cy_s [N+1];
	logic signed [ZW-1:0] cz_s [N+1];
	flags_t cf_s [N+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s[0] <= XW'(dot_shr[NW-1:0]);
			cy_s[0] <= XW'(crs_shr[NW-1:0]);
			cz_s[0] <= '0;
			cf_s[0] <= fl_in;
		end
	end

	// CORDIC vectoring, one iteration per stage
	for (genvar i = 0; i < N; i++) begin : g_cordic
		logic signed [XW-1:0] xs, ys;
		logic signed [ZW-1:0] au;
		assign xs = cx_s[i] >>> i;
		assign ys = cy_s[i] >>> i;
		assign au = ZW'(ATAN_UNITS[i]);

		always_ff @(posedge clk) begin
			if (adv) begin
				if (cy_s[i][XW-1]) begin
					cx_s[i+1] <= cx_s[i] - ys;
					cy_s[i+1] <= cy_s[i] + xs;
					cz_s[i+1] <= cz_s[i] - au;
				end else begin
					cx_s[i+1] <= cx_s[i] + ys;
					cy_s[i+1] <= cy_s[i] - xs;
					cz_s[i+1] <= cz_s[i] + au;
				end
				cf_s[i+1] <= cf_s[i];
			end
		end
	end

	// clamp and scale to degrees
	logic [ZQ_W-1:0] z_clamp;
	logic [PROD_DEG_W-1:0] z_deg;
	logic [ACUTE_W-1:0] acute_sd;
	flags_t fl_sd;

	always_comb begin
		if (cz_s[N][ZW-1]) begin
			z_clamp = '0;
		end else if (cz_s[N][ZW-2:0] > (ZW-1)'(TURN_QUARTER)) begin
			z_clamp = TURN_QUARTER;
		end else begin
			z_clamp = cz_s[N][ZQ_W-1:0];
		end
		z_deg = PROD_DEG_W'(z_clamp) * PROD_DEG_W'(DEG_PER_TURN);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			acute_sd <= z_deg[32 +: ACUTE_W];
			fl_sd <= cf_s[N];
		end
	end

	// quadrant and sign fix-up
	logic signed [ANGLE_W-1:0] ang;

	always_comb begin
		if (fl_sd.zero_vec) begin
			ang = DEG_RIGHT;
		end else if (fl_sd.crs_zero) begin
			ang = fl_sd.dot_neg ? DEG_STRAIGHT : DEG_ZERO;
		end else begin
			ang = fl_sd.dot_zero ? DEG_RIGHT : ANGLE_W'(acute_sd);
			if (fl_sd.dot_neg) ang = DEG_STRAIGHT - ang;
			if (fl_sd.crs_neg) ang = -ang;
		end
	end

	logic signed [ANGLE_W-1:0] angle_so;

	always_ff @(posedge clk) begin
		if (adv) begin
			angle_so <= ang;
		end
	end

	assign angle_deg = angle_so;

endmodule
